[rtl/core/ipjs_pkg.sv]
// ipjs_pkg: shared types and constants for the IP range jump search lookup.
// No dependencies; compiled first.
`default_nettype none

package ipjs_pkg;

    // Field widths of the item and result channels
    localparam int OP_W     = 1;
    localparam int INDEX_W  = 16;
    localparam int ADDR_W   = 32;
    localparam int LOC_W    = 32;
    localparam int COUNT_W  = 17;

    // Item operation codes
    localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 1'b1;

    // Jump steps of the second, third and fourth search levels
    localparam int STEP_LEVEL1 = 10000;
    localparam int STEP_LEVEL2 = 100;
    localparam int STEP_LEVEL3 = 1;

    localparam logic [1:0] LEVEL_FIRST = 2'd0;
    localparam logic [1:0] LEVEL_SECOND = 2'd1;
    localparam logic [1:0] LEVEL_THIRD = 2'd2;
    localparam logic [1:0] LEVEL_LAST  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_COMPARE,
        ST_FINAL_READ,
        ST_FINAL_CHECK,
        ST_DONE
    } state_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic lookup_fire;
        logic step_zero;
        logic high_hit;
        logic last_level;
        logic out_free;
    } status_t;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic in_ready;
        logic step_take;
        logic set_miss;
        logic advance;
        logic level_up;
        logic rd_final;
        logic take_final;
        logic out_load;
    } ctrl_t;

endpackage

`default_nettype wire

[rtl/core/ipjs_if.sv]
// ipjs_if: valid/ready channel interfaces for lookup items and results.
// Depends on ipjs_pkg for field widths.
`default_nettype none

interface ipjs_req_if;
    logic                             valid;
    logic                             ready;
    logic [ipjs_pkg::OP_W-1:0]        op;
    logic [ipjs_pkg::INDEX_W-1:0]     entry_index;
    logic [ipjs_pkg::ADDR_W-1:0]      low_address;
    logic [ipjs_pkg::ADDR_W-1:0]      high_address;
    logic [ipjs_pkg::LOC_W-1:0]       location_id;
    logic [ipjs_pkg::ADDR_W-1:0]      query_address;

    modport source (
        output valid, op, entry_index, low_address, high_address, location_id,
               query_address,
        input  ready
    );
    modport sink (
        input  valid, op, entry_index, low_address, high_address, location_id,
               query_address,
        output ready
    );
endinterface

interface ipjs_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [ipjs_pkg::INDEX_W-1:0]     range_index;
    logic [ipjs_pkg::LOC_W-1:0]       matched_location;

    modport source (
        output valid, found, range_index, matched_location,
        input  ready
    );
    modport sink (
        input  valid, found, range_index, matched_location,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/ipjs_table.sv]
// ipjs_table: range table memory (low, high, location), one write and one read port.
// Read data registered; no dependencies beyond the parameters passed in.
`default_nettype none

module ipjs_table #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [31:0]       wr_low,
    input  wire logic [31:0]       wr_high,
    input  wire logic [31:0]       wr_loc,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [31:0]       rd_low,
    output logic      [31:0]       rd_high,
    output logic      [31:0]       rd_loc
);

    logic [31:0] low_mem  [DEPTH];
    logic [31:0] high_mem [DEPTH];
    logic [31:0] loc_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            low_mem[wr_addr]  <= wr_low;
            high_mem[wr_addr] <= wr_high;
            loc_mem[wr_addr]  <= wr_loc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_low  <= low_mem[rd_addr];
            rd_high <= high_mem[rd_addr];
            rd_loc  <= loc_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/ipjs_step_unit.sv]
// ipjs_step_unit: shared add / clamp unit of the jump search.
// Gives from+step, the step clamped to the entries left, and the probe address.
`default_nettype none

module ipjs_step_unit #(
    parameter int W      = 21,
    parameter int ADDR_W = 16
) (
    input  wire logic [W-1:0]      from_pos,
    input  wire logic [W-1:0]      step,
    input  wire logic [W-1:0]      count,
    output logic      [W-1:0]      sum,
    output logic      [W-1:0]      step_clamped,
    output logic                   step_zero,
    output logic      [ADDR_W-1:0] probe_addr
);

    logic       clamp;
    logic [W-1:0] last_probe;

    always_comb
    begin
        sum          = from_pos + step;
        clamp        = (sum >= count);
        step_clamped = clamp ? (count - from_pos) : step;
        step_zero    = (step_clamped == '0);
        // last entry of the span; count-1 when clamped
        last_probe   = (clamp ? count : sum) - W'(1);
        probe_addr   = last_probe[ADDR_W-1:0];
    end

endmodule

`default_nettype wire

[rtl/core/ipjs_ctrl.sv]
// ipjs_ctrl: sequencer of the four-level jump search.
// Depends on ipjs_pkg (state_t, status_t, ctrl_t).
`default_nettype none

module ipjs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ipjs_pkg::status_t sts,
    output ipjs_pkg::ctrl_t        ctl
);

    ipjs_pkg::state_t state_reg;
    ipjs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ipjs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ipjs_pkg::ST_IDLE:
                if (sts.lookup_fire)
                    state_next = ipjs_pkg::ST_CLAMP;
            ipjs_pkg::ST_CLAMP:
                state_next = sts.step_zero ? ipjs_pkg::ST_DONE : ipjs_pkg::ST_COMPARE;
            ipjs_pkg::ST_COMPARE:
                if (sts.high_hit && sts.last_level)
                    state_next = ipjs_pkg::ST_FINAL_READ;
                else
                    state_next = ipjs_pkg::ST_CLAMP;
            ipjs_pkg::ST_FINAL_READ:
                state_next = ipjs_pkg::ST_FINAL_CHECK;
            ipjs_pkg::ST_FINAL_CHECK:
                state_next = ipjs_pkg::ST_DONE;
            ipjs_pkg::ST_DONE:
                if (sts.out_free)
                    state_next = ipjs_pkg::ST_IDLE;
            default:
                state_next = ipjs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ipjs_pkg::ST_IDLE:
                ctl.in_ready = 1'b1;
            ipjs_pkg::ST_CLAMP:
            begin
                ctl.step_take = !sts.step_zero;
                ctl.set_miss  = sts.step_zero;
            end
            ipjs_pkg::ST_COMPARE:
            begin
                ctl.advance  = !sts.high_hit;
                ctl.level_up = sts.high_hit && !sts.last_level;
            end
            ipjs_pkg::ST_FINAL_READ:
                ctl.rd_final = 1'b1;
            ipjs_pkg::ST_FINAL_CHECK:
                ctl.take_final = 1'b1;
            ipjs_pkg::ST_DONE:
                ctl.out_load = sts.out_free;
            default:
                ctl = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/ip_range_jump_search_lookup.sv]
// ip_range_jump_search_lookup: top level of the IP range lookup by jump search.
// Depends on ipjs_pkg, ipjs_if, ipjs_table, ipjs_step_unit and ipjs_ctrl.
//
//  channel | dir | handshake           | carries
//  --------+-----+---------------------+--------------------------------------------
//  req     | in  | valid/ready         | op, entry_index, low/high_address,
//          |     |                     | location_id, query_address
//  rsp     | out | valid/ready         | found, range_index, matched_location
//  cfg     | in  | cfg_wr_en, no stall | cfg_wr_data -> entry_count
//
// A write item gives no result and leaves the block ready for the next item.
// A lookup item is answered after P table probes over the four levels (at most
// 1 + 7 + 100 + 100 for 65536 entries), then a final read and check of the found
// entry; a search that runs past the last entry ends as a miss with no final read.
// The single table read port and the shared step unit serialise the probes: one
// probe is a clamp state that reads the table and a compare state that advances or
// ends the level.
// Reset clears the sequencer, the result valid and entry_count; the table is not
// cleared. A stalled result holds in the output register; the block stays busy
// until the result is loaded there, then takes the next item.
`default_nettype none

module ip_range_jump_search_lookup #(
    parameter int TABLE_DEPTH = 65536,
    parameter int FIRST_STEP  = 1000000
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    ipjs_req_if.sink                           req,
    ipjs_rsp_if.source                         rsp,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ipjs_pkg::COUNT_W-1:0]  cfg_wr_data
);

    // table address, position (holds TABLE_DEPTH itself) and step widths
    localparam int MEM_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int POS_W  = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_W0 = $clog2(FIRST_STEP + 1);
    localparam int STEP_W = (STEP_W0 > 14) ? STEP_W0 : 14;
    // one spare bit so from+step never wraps
    localparam int W = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;

    ipjs_pkg::status_t sts;
    ipjs_pkg::ctrl_t   ctl;

    logic [ipjs_pkg::COUNT_W-1:0] entry_count_reg;

    logic [ipjs_pkg::ADDR_W-1:0]  query_reg;
    logic [W-1:0]                 count_reg;
    logic [W-1:0]                 pos_reg;
    logic [W-1:0]                 pos_next;
    logic [W-1:0]                 step_reg;
    logic [W-1:0]                 step_next;
    logic [1:0]                   level_reg;
    logic [1:0]                   level_next;
    logic                         found_reg;
    logic [ipjs_pkg::LOC_W-1:0]   loc_reg;

    logic                         rsp_valid_reg;
    logic                         rsp_found_reg;
    logic [ipjs_pkg::INDEX_W-1:0] rsp_index_reg;
    logic [ipjs_pkg::LOC_W-1:0]   rsp_loc_reg;

    logic                         req_fire;
    logic                         slot_ok;
    logic                         tbl_wr_en;
    logic                         tbl_rd_en;
    logic [MEM_AW-1:0]            tbl_rd_addr;
    logic [31:0]                  rd_low;
    logic [31:0]                  rd_high;
    logic [31:0]                  rd_loc;

    logic [W-1:0]                 unit_sum;
    logic [W-1:0]                 unit_step;
    logic                         unit_zero;
    logic [MEM_AW-1:0]            unit_addr;

    logic [W-1:0]                 count_clamped;
    logic [W-1:0]                 level_step;

    // ---------------- item intake ----------------
    assign req.ready = ctl.in_ready;
    assign req_fire  = req.valid && ctl.in_ready;
    assign slot_ok   = 32'(req.entry_index) < 32'(TABLE_DEPTH);
    assign tbl_wr_en = req_fire && (req.op == ipjs_pkg::OP_WRITE) && slot_ok;

    // entry_count above the table depth is taken as the depth
    assign count_clamped = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ? W'(TABLE_DEPTH)
                                                                     : W'(entry_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_count_reg <= '0;
        else if (cfg_wr_en)
            entry_count_reg <= cfg_wr_data;
    end

    // ---------------- table ----------------
    assign tbl_rd_en   = ctl.step_take || ctl.rd_final;
    assign tbl_rd_addr = ctl.rd_final ? pos_reg[MEM_AW-1:0] : unit_addr;

    ipjs_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (MEM_AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (MEM_AW'(req.entry_index)),
        .wr_low  (req.low_address),
        .wr_high (req.high_address),
        .wr_loc  (req.location_id),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_low  (rd_low),
        .rd_high (rd_high),
        .rd_loc  (rd_loc)
    );

    // ---------------- shared step unit ----------------
    // CLAMP: clamps step_reg against the entries left and gives the probe address.
    // COMPARE: its sum is the next position when the probe missed.
    ipjs_step_unit #(
        .W      (W),
        .ADDR_W (MEM_AW)
    ) u_step (
        .from_pos     (pos_reg),
        .step         (step_reg),
        .count        (count_reg),
        .sum          (unit_sum),
        .step_clamped (unit_step),
        .step_zero    (unit_zero),
        .probe_addr   (unit_addr)
    );

    // step of the level that follows level_reg
    always_comb
    begin
        case (level_reg)
            ipjs_pkg::LEVEL_FIRST:  level_step = W'(ipjs_pkg::STEP_LEVEL1);
            ipjs_pkg::LEVEL_SECOND: level_step = W'(ipjs_pkg::STEP_LEVEL2);
            ipjs_pkg::LEVEL_THIRD:  level_step = W'(ipjs_pkg::STEP_LEVEL3);
            default:                level_step = W'(ipjs_pkg::STEP_LEVEL3);
        endcase
    end

    // ---------------- sequencer ----------------
    assign sts.lookup_fire = req_fire && (req.op == ipjs_pkg::OP_LOOKUP);
    assign sts.step_zero   = unit_zero;
    assign sts.high_hit    = (rd_high >= query_reg);
    assign sts.last_level  = (level_reg == ipjs_pkg::LEVEL_LAST);
    assign sts.out_free    = !rsp_valid_reg || rsp.ready;

    ipjs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    // ---------------- search registers ----------------
    always_comb
    begin
        pos_next   = pos_reg;
        step_next  = step_reg;
        level_next = level_reg;
        if (sts.lookup_fire)
        begin
            pos_next   = '0;
            step_next  = W'(FIRST_STEP);
            level_next = ipjs_pkg::LEVEL_FIRST;
        end
        else if (ctl.step_take)
            step_next = unit_step;
        else if (ctl.advance)
            pos_next = unit_sum;
        else if (ctl.level_up)
        begin
            step_next  = level_step;
            level_next = level_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        step_reg  <= step_next;
        level_reg <= level_next;
        if (sts.lookup_fire)
        begin
            query_reg <= req.query_address;
            count_reg <= count_clamped;
        end
        if (ctl.set_miss)
            found_reg <= 1'b0;
        else if (ctl.take_final)
            found_reg <= (rd_low <= query_reg);
        if (ctl.take_final)
            loc_reg <= rd_loc;
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (ctl.out_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            rsp_found_reg <= found_reg;
            rsp_index_reg <= found_reg ? ipjs_pkg::INDEX_W'(pos_reg) : '0;
            rsp_loc_reg   <= found_reg ? loc_reg : '0;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.found            = rsp_found_reg;
    assign rsp.range_index      = rsp_index_reg;
    assign rsp.matched_location = rsp_loc_reg;

endmodule

`default_nettype wire

[rtl/core/ipjs_checker.sv]
// ipjs_checker: port-level assertions for the IP range jump search lookup.
// Depends on ipjs_pkg; bound to ip_range_jump_search_lookup at the end of this file.
`default_nettype none

module ipjs_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           req_valid,
    input wire logic                           req_ready,
    input wire logic [ipjs_pkg::OP_W-1:0]      req_op,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic                           rsp_found,
    input wire logic [ipjs_pkg::INDEX_W-1:0]   rsp_range_index,
    input wire logic [ipjs_pkg::LOC_W-1:0]     rsp_matched_location
);

    // a result waiting on the sink holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
            && $stable(rsp_range_index) && $stable(rsp_matched_location))
        else $error("stalled result changed");

    // a miss carries zero index and location
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_range_index == '0 && rsp_matched_location == '0)
        else $error("miss with non-zero payload");

    // a lookup keeps the block busy in the next cycle
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_op == ipjs_pkg::OP_LOOKUP |=> !req_ready)
        else $error("ready right after a lookup item");

    // a write item leaves the block ready in the next cycle
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_op == ipjs_pkg::OP_WRITE |=> req_ready)
        else $error("not ready right after a write item");

    // no result in the cycle after an edge in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("result valid during reset");

endmodule

bind ip_range_jump_search_lookup ipjs_checker u_ipjs_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req.valid),
    .req_ready            (req.ready),
    .req_op               (req.op),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_found            (rsp.found),
    .rsp_range_index      (rsp.range_index),
    .rsp_matched_location (rsp.matched_location)
);

`default_nettype wire
